@@ sv/gbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;
    localparam int MaxDet = 64;
    localparam int CntW = $clog2(MaxDet + 1);

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] score;
        logic [3:0]  label;
        logic [7:0]  gw;
    } det_t;

    typedef struct packed {
        logic load;
        logic shift;
        det_t item;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

@@ sv/greedy_box_suppression.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Greedy box suppression.
// Detections are started one per cycle (start high, busy low). Each one is
// inserted into a sorted chain of cells in the same cycle, so loading runs
// at one transaction per cycle. The item with last_item set ends the set:
// busy rises, the chain shifts its head out one entry per cycle, strongest
// first, and each head is checked against a row of kept positions. A kept
// head waits in a pending register until the next kept head is found or
// the chain runs empty, then is presented for one cycle with strobe high.
// After the last item, busy stays high while the chain drains, so the
// number of stored detections sets how long a set is busy. The final
// kept result carries last_result; overflow is high on every result of a
// set in which items past 64 were dropped. Results cannot be stalled.
// A set whose items past 64 are dropped still yields results from what is
// stored. Reset empties the chain and sets both cell registers to 16.
// Configuration writes (we, index, wdata) are taken any idle cycle.
module greedy_box_suppression
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        we,
    input  wire logic        index,
    input  wire logic [7:0]  wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] pos_x,
    input  wire logic [11:0] pos_y,
    input  wire logic [15:0] match_score,
    input  wire logic [3:0]  label,
    input  wire logic [7:0]  glyph_width,
    input  wire logic        last_item,
    output logic             strobe,
    output logic [11:0]      kept_x,
    output logic [11:0]      kept_y,
    output logic [15:0]      kept_score,
    output logic [3:0]       kept_label,
    output logic [7:0]       kept_width,
    output logic             last_result,
    output logic             overflow
);
    import gbs_pkg::*;

    localparam logic IdxWidth = 1'b0;

    state_t          state_reg, state_next;
    logic [7:0]      cw_reg, ch_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            pend_reg, pend_next;
    det_t            pend_det_reg;
    logic            str_reg;
    logic            lr_reg;
    det_t            out_reg;
    logic            ovo_reg;

    cell_ctl_t       ctl;
    logic            accept, full;
    logic            cv [MaxDet];
    logic            ct [MaxDet];
    det_t            cd [MaxDet];
    logic            head_valid, near, push, drain_end;

    assign accept = start && !busy;
    assign full   = (cnt_reg == CntW'(MaxDet));
    assign ctl.load  = accept && !full;
    assign ctl.shift = (state_reg == ST_DRAIN);
    assign ctl.item  = '{x: pos_x, y: pos_y, score: match_score,
                         label: label, gw: glyph_width};

    for (genvar g = 0; g < MaxDet; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            gbs_cell u_cell (.clk, .rst_n, .ctl,
                .prev_valid(cv[1]), .prev_takes(1'b0), .prev_det(cd[1]),
                .valid(cv[0]), .takes(ct[0]), .det(cd[0]));
        end
        else if (g == MaxDet - 1)
        begin : g_tail
            gbs_cell u_cell (.clk, .rst_n, .ctl,
                .prev_valid(ctl.shift ? 1'b0 : cv[g-1]),
                .prev_takes(ct[g-1]), .prev_det(cd[g-1]),
                .valid(cv[g]), .takes(ct[g]), .det(cd[g]));
        end
        else
        begin : g_mid
            gbs_cell u_cell (.clk, .rst_n, .ctl,
                .prev_valid(ctl.shift ? cv[g+1] : cv[g-1]),
                .prev_takes(ct[g-1]),
                .prev_det(ctl.shift ? cd[g+1] : cd[g-1]),
                .valid(cv[g]), .takes(ct[g]), .det(cd[g]));
        end
    end

    assign head_valid = cv[0];
    assign push       = ctl.shift && head_valid && !near;
    assign drain_end  = ctl.shift && !head_valid;

    gbs_kept u_kept (.clk, .rst_n, .clear(drain_end), .push,
        .cand(cd[0]), .cell_width(cw_reg), .cell_height(ch_reg), .near);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (accept && last_item) state_next = ST_DRAIN;
            ST_DRAIN: if (!head_valid) state_next = ST_EMIT;
            ST_EMIT:  state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != ST_LOAD);
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        pend_next = pend_reg;
        if (ctl.load)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        if (accept && full)
        begin
            ovf_next = 1'b1;
        end
        if (push)
        begin
            pend_next = 1'b1;
        end
        if (state_reg == ST_EMIT)
        begin
            cnt_next  = '0;
            ovf_next  = 1'b0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cw_reg    <= 8'd16;
            ch_reg    <= 8'd16;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            str_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            // pending kept head goes out when the next one arrives or at end
            str_reg   <= pend_reg && (push || drain_end);
            if (we)
            begin
                if (index == IdxWidth)
                begin
                    cw_reg <= wdata;
                end
                else
                begin
                    ch_reg <= wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && (push || drain_end))
        begin
            out_reg <= pend_det_reg;
            lr_reg  <= drain_end;
            ovo_reg <= ovf_reg;
        end
        if (push)
        begin
            pend_det_reg <= cd[0];
        end
    end

    assign strobe      = str_reg;
    assign kept_x      = out_reg.x;
    assign kept_y      = out_reg.y;
    assign kept_score  = out_reg.score;
    assign kept_label  = out_reg.label;
    assign kept_width  = out_reg.gw;
    assign last_result = lr_reg;
    assign overflow    = ovo_reg;
endmodule
`default_nettype wire

@@ sv/gbs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbs_cell
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gbs_pkg::cell_ctl_t ctl,
    input  wire logic             prev_valid,
    input  wire logic             prev_takes,
    input  wire gbs_pkg::det_t    prev_det,
    output logic                  valid,
    output logic                  takes,
    output gbs_pkg::det_t         det
);
    import gbs_pkg::*;

    logic  valid_reg, valid_next;
    det_t  det_reg, det_next;

    // new item goes here if it beats this cell (ties stay behind)
    assign takes = !valid_reg || (ctl.item.score > det_reg.score);
    assign valid = valid_reg;
    assign det   = det_reg;

    always_comb
    begin
        valid_next = valid_reg;
        det_next   = det_reg;
        if (ctl.load && takes)
        begin
            valid_next = 1'b1;
            det_next   = prev_takes ? prev_det : ctl.item;
            if (prev_takes && !prev_valid)
            begin
                valid_next = 1'b0;
            end
        end
        else if (ctl.shift)
        begin
            valid_next = prev_valid;
            det_next   = prev_det;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
    end
endmodule
`default_nettype wire

@@ sv/gbs_kept.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gbs_kept
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire logic        push,
    input  wire gbs_pkg::det_t cand,
    input  wire logic [7:0]  cell_width,
    input  wire logic [7:0]  cell_height,
    output logic             near
);
    import gbs_pkg::*;

    logic [MaxDet-1:0] kv_reg, kv_next;
    logic [11:0]       kx_reg [MaxDet];
    logic [11:0]       ky_reg [MaxDet];
    logic [MaxDet-1:0] hit;

    always_comb
    begin
        logic [12:0] dx, dy;
        for (int i = 0; i < MaxDet; i++)
        begin
            dx = (cand.x > kx_reg[i]) ? {1'b0, cand.x - kx_reg[i]}
                                      : {1'b0, kx_reg[i] - cand.x};
            dy = (cand.y > ky_reg[i]) ? {1'b0, cand.y - ky_reg[i]}
                                      : {1'b0, ky_reg[i] - cand.y};
            hit[i] = kv_reg[i] && ({dx, 1'b0} < {6'd0, cell_width})
                     && ({dy, 1'b0} < {6'd0, cell_height});
        end
    end
    assign near = |hit;

    always_comb
    begin
        kv_next = kv_reg;
        if (clear)
        begin
            kv_next = '0;
        end
        else if (push)
        begin
            kv_next = {kv_reg[MaxDet-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kv_reg <= '0;
        end
        else
        begin
            kv_reg <= kv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kx_reg[0] <= cand.x;
            ky_reg[0] <= cand.y;
            for (int i = 1; i < MaxDet; i++)
            begin
                kx_reg[i] <= kx_reg[i-1];
                ky_reg[i] <= ky_reg[i-1];
            end
        end
    end
endmodule
`default_nettype wire
